### rtl/mct_pkg.sv
`timescale 1ns / 1ps

package mct_pkg;

  // Request opcodes.
  localparam logic [2:0] OP_CREATE  = 3'd0;
  localparam logic [2:0] OP_START   = 3'd1;
  localparam logic [2:0] OP_STOP    = 3'd2;
  localparam logic [2:0] OP_SETDUR  = 3'd3;
  localparam logic [2:0] OP_SETMODE = 3'd4;
  localparam logic [2:0] OP_DESTROY = 3'd5;
  localparam logic [2:0] OP_TICK    = 3'd6;

  // Result kinds.
  localparam logic [1:0] KIND_ACK      = 2'd0;
  localparam logic [1:0] KIND_EXPIRED  = 2'd1;
  localparam logic [1:0] KIND_ERROR    = 2'd2;
  localparam logic [1:0] KIND_TICKDONE = 2'd3;

  // Timer modes.
  localparam logic [1:0] MODE_ONESHOT = 2'd0;
  localparam logic [1:0] MODE_LOOP    = 2'd1;
  localparam logic [1:0] MODE_DESTROY = 2'd2;

  // Width of the slot and index fields.
  localparam int SLOT_BITS = 4;

  // Token that walks down the row of timer cells, one cell per cycle while the row is not stalled.
  typedef struct packed {
    logic                 valid;
    logic [2:0]           op;
    logic [SLOT_BITS-1:0] idx;
    logic [1:0]           mode;
    logic                 bad;   // zero duration or unused mode for this opcode
    logic                 done;  // some cell has carried out the request
    logic [SLOT_BITS-1:0] slot;  // slot that carried it out
  } mct_tok_t;

endpackage

### rtl/mct_cell.sv
`timescale 1ns / 1ps

module mct_cell
  import mct_pkg::*;
#(
  parameter int INDEX     = 0,
  parameter int TIME_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic [TIME_BITS-1:0] amt,
  input  mct_tok_t             tok_in,
  output mct_tok_t             tok_out,
  output logic                 expired
);

  localparam bit                   ADDRESSABLE = INDEX < (1 << SLOT_BITS);
  localparam logic [SLOT_BITS-1:0] MY_SLOT     = SLOT_BITS'(INDEX);

  logic                 alive;
  logic                 running;
  logic [1:0]           mode;
  logic [TIME_BITS-1:0] duration;
  logic [TIME_BITS-1:0] elapsed;

  logic                 alive_next;
  logic                 running_next;
  logic [1:0]           mode_next;
  logic [TIME_BITS-1:0] duration_next;
  logic [TIME_BITS-1:0] elapsed_next;
  mct_tok_t             tok_next;

  logic [TIME_BITS:0]   sum;
  logic [TIME_BITS-1:0] elapsed_sat;
  logic                 mine;

  // Saturating advance of the elapsed time and the slot match.
  always_comb begin
    sum         = {1'b0, elapsed} + {1'b0, amt};
    elapsed_sat = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
    mine        = ADDRESSABLE && (tok_in.idx == MY_SLOT);
  end

  // Apply the request held by the token when it passes this cell.
  always_comb begin
    alive_next    = alive;
    running_next  = running;
    mode_next     = mode;
    duration_next = duration;
    elapsed_next  = elapsed;
    tok_next      = tok_in;
    expired       = 1'b0;
    if (tok_in.valid) begin
      case (tok_in.op)
        OP_CREATE: begin
          if (!tok_in.bad && !tok_in.done && !alive) begin
            alive_next    = 1'b1;
            running_next  = 1'b0;
            mode_next     = tok_in.mode;
            duration_next = amt;
            elapsed_next  = '0;
            tok_next.done = 1'b1;
            tok_next.slot = MY_SLOT;
          end
        end
        OP_START: begin
          if (mine && alive) begin
            elapsed_next  = '0;
            running_next  = 1'b1;
            tok_next.done = 1'b1;
            tok_next.slot = MY_SLOT;
          end
        end
        OP_STOP: begin
          if (mine && alive) begin
            running_next  = 1'b0;
            tok_next.done = 1'b1;
            tok_next.slot = MY_SLOT;
          end
        end
        OP_SETDUR: begin
          if (mine && alive && !tok_in.bad) begin
            duration_next = amt;
            tok_next.done = 1'b1;
            tok_next.slot = MY_SLOT;
          end
        end
        OP_SETMODE: begin
          if (mine && alive && !tok_in.bad) begin
            mode_next     = tok_in.mode;
            tok_next.done = 1'b1;
            tok_next.slot = MY_SLOT;
          end
        end
        OP_DESTROY: begin
          if (mine && alive) begin
            alive_next    = 1'b0;
            running_next  = 1'b0;
            tok_next.done = 1'b1;
            tok_next.slot = MY_SLOT;
          end
        end
        OP_TICK: begin
          if (alive && running) begin
            elapsed_next = elapsed_sat;
            if (elapsed_sat >= duration) begin
              expired = 1'b1;
              if (mode == MODE_LOOP) begin
                elapsed_next = '0;
              end else begin
                running_next = 1'b0;
                if (mode == MODE_DESTROY) begin
                  alive_next = 1'b0;
                end
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Control state and the token register toward the next cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      alive   <= 1'b0;
      running <= 1'b0;
      tok_out <= '0;
    end else if (adv) begin
      alive   <= alive_next;
      running <= running_next;
      tok_out <= tok_next;
    end
  end

  // Timer payload.
  always_ff @(posedge clk) begin
    if (adv) begin
      mode     <= mode_next;
      duration <= duration_next;
      elapsed  <= elapsed_next;
    end
  end

endmodule

### rtl/multi_channel_timer_bank.sv
`timescale 1ns / 1ps
// Each request walks a row of NUM_TIMERS timer cells, one cell per cycle while the row is not
// stalled, and a new request is accepted only once the last one has left the row (busy clears).
// Its final result comes from the last cell's token through the output register; a tick
// sends each expiry as its token passes that cell, and a held output stalls the whole row.
// Reset (rst, synchronous) frees every slot, stops every timer and empties the row.

module multi_channel_timer_bank
  import mct_pkg::*;
#(
  parameter int NUM_TIMERS = 16,
  parameter int TIME_BITS  = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // timer_index[3:0], amount[35:4], loop_mode[37:36], zero
  input  logic [2:0]  s_tuser,   // opcode[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // slot[3:0], zero
  output logic [1:0]  m_tuser,   // kind[1:0]
  output logic        m_tlast    // last
);

  mct_tok_t             tok_chain [NUM_TIMERS+1];
  mct_tok_t             head;
  logic [NUM_TIMERS-1:0] evt_vec;
  logic [TIME_BITS-1:0] item_amt;
  logic                 busy;
  logic                 accept;
  logic                 adv;
  logic                 evt_any;
  logic                 tail_req;
  logic [SLOT_BITS-1:0] evt_slot;
  logic [1:0]           res_kind;
  logic [SLOT_BITS-1:0] res_slot;
  logic [TIME_BITS-1:0] in_amt;
  logic [2:0]           in_op;
  logic [1:0]           in_mode;
  logic                 in_bad;
  mct_tok_t             tail;

  assign s_tready = !busy;
  assign accept   = s_tvalid && s_tready;

  // Unpack the request and flag zero durations and unused modes up front.
  always_comb begin
    in_op   = s_tuser;
    in_mode = s_tdata[37:36];
    in_amt  = TIME_BITS'(s_tdata[35:4]);
    case (in_op)
      OP_CREATE:  in_bad = (in_amt == '0) || (in_mode > MODE_DESTROY);
      OP_SETDUR:  in_bad = (in_amt == '0);
      OP_SETMODE: in_bad = (in_mode > MODE_DESTROY);
      default:    in_bad = 1'b0;
    endcase
  end

  // The entry register feeds the first cell.
  assign tok_chain[0] = head;

  // Row of timer cells.
  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
    mct_cell #(
      .INDEX     (i),
      .TIME_BITS (TIME_BITS)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .amt     (item_amt),
      .tok_in  (tok_chain[i]),
      .tok_out (tok_chain[i+1]),
      .expired (evt_vec[i])
    );
  end

  assign tail = tok_chain[NUM_TIMERS];

  // Locate the expiring cell; at most one cell holds the token.
  always_comb begin
    evt_slot = '0;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      if (evt_vec[i]) begin
        evt_slot = SLOT_BITS'(i);
      end
    end
  end

  assign evt_any  = |evt_vec;
  assign tail_req = tail.valid;
  assign adv      = !(evt_any || tail_req) || !m_tvalid || m_tready;

  // Final result of a request once its token leaves the last cell.
  always_comb begin
    if (tail.op == OP_TICK) begin
      res_kind = KIND_TICKDONE;
      res_slot = '0;
    end else if (tail.done) begin
      res_kind = KIND_ACK;
      res_slot = tail.slot;
    end else if (tail.op == OP_CREATE) begin
      res_kind = KIND_ERROR;
      res_slot = '0;
    end else begin
      res_kind = KIND_ERROR;
      res_slot = tail.idx;
    end
  end

  // Entry of the row, busy flag and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      busy     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        head.valid <= 1'b1;
        head.op    <= in_op;
        head.idx   <= s_tdata[3:0];
        head.mode  <= in_mode;
        head.bad   <= in_bad;
        head.done  <= 1'b0;
        head.slot  <= '0;
        busy       <= 1'b1;
      end else if (adv) begin
        head.valid <= 1'b0;
        if (tail_req) begin
          busy <= 1'b0;
        end
      end
      if (adv && (evt_any || tail_req)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Request payload and result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_amt <= in_amt;
    end
    if (adv && evt_any) begin
      m_tuser <= KIND_EXPIRED;
      m_tdata <= {4'b0, evt_slot};
      m_tlast <= 1'b0;
    end else if (adv && tail_req) begin
      m_tuser <= res_kind;
      m_tdata <= {4'b0, res_slot};
      m_tlast <= 1'b1;
    end
  end

  // Only one token is ever in flight, so no two cells expire at once.
  assert property (@(posedge clk) disable iff (rst) $onehot0(evt_vec))
    else $error("more than one timer cell reports an expiry");

  // An idle bank holds no token at either end of the row.
  assert property (@(posedge clk) disable iff (rst)
    !busy |-> (!head.valid && !tail.valid && !evt_any))
    else $error("token present while the bank is idle");

  // An accepted request leaves the bank busy in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    accept |=> (busy && head.valid))
    else $error("accepted request did not enter the row");

  // The final result of a request is always marked last.
  assert property (@(posedge clk) disable iff (rst)
    (adv && tail_req && !evt_any) |=> (m_tvalid && m_tlast))
    else $error("final result not flagged as last");

endmodule

### tb/tb_multi_channel_timer_bank.sv
`timescale 1ns / 1ps

module tb_multi_channel_timer_bank;
  import mct_pkg::*;

  localparam int TIMERS        = 16;
  localparam int TAIL_CYCLES   = 4 * (TIMERS + 2);
  localparam int STALL_LIMIT   = 4000;
  localparam int RANDOM_ITEMS  = 230;
  localparam int REPORT_LIMIT  = 10;

  // Codes the block must refuse.
  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam logic [1:0] MODE_BAD  = 2'd3;

  typedef struct {
    logic [1:0] kind;
    logic [3:0] slot;
    logic       last;
  } timer_event_t;

  // Tracks the timer bank state and the events that each request must produce.
  class timer_scoreboard;
    bit           alive[TIMERS];
    bit           running[TIMERS];
    logic [1:0]   mode[TIMERS];
    logic [31:0]  duration[TIMERS];
    logic [31:0]  elapsed[TIMERS];
    timer_event_t events_due[$];
    int           mismatches;

    function void add_event(logic [1:0] kind, logic [3:0] slot, logic last);
      timer_event_t e;
      e.kind = kind;
      e.slot = slot;
      e.last = last;
      events_due.push_back(e);
    endfunction

    function int pending();
      return events_due.size();
    endfunction

    // Apply one accepted request to the bank and queue the events it causes.
    function void note_request(logic [2:0] op, logic [3:0] idx, logic [31:0] amt,
                               logic [1:0] lmode);
      bit          placed;
      logic [32:0] sum;
      placed = 0;
      case (op)
        OP_CREATE: begin
          if (amt == 0 || lmode > MODE_DESTROY) begin
            add_event(KIND_ERROR, 4'd0, 1'b1);
          end else begin
            // Take the lowest free slot.
            for (int s = 0; s < TIMERS; s++) begin
              if (!placed && !alive[s]) begin
                alive[s]    = 1;
                running[s]  = 0;
                mode[s]     = lmode;
                duration[s] = amt;
                elapsed[s]  = '0;
                add_event(KIND_ACK, s[3:0], 1'b1);
                placed = 1;
              end
            end
            if (!placed) add_event(KIND_ERROR, 4'd0, 1'b1);
          end
        end
        OP_START: begin
          if (alive[idx]) begin
            elapsed[idx] = '0;
            running[idx] = 1;
            add_event(KIND_ACK, idx, 1'b1);
          end else begin
            add_event(KIND_ERROR, idx, 1'b1);
          end
        end
        OP_STOP: begin
          if (alive[idx]) begin
            running[idx] = 0;
            add_event(KIND_ACK, idx, 1'b1);
          end else begin
            add_event(KIND_ERROR, idx, 1'b1);
          end
        end
        OP_SETDUR: begin
          if (alive[idx] && amt != 0) begin
            duration[idx] = amt;
            add_event(KIND_ACK, idx, 1'b1);
          end else begin
            add_event(KIND_ERROR, idx, 1'b1);
          end
        end
        OP_SETMODE: begin
          if (alive[idx] && lmode <= MODE_DESTROY) begin
            mode[idx] = lmode;
            add_event(KIND_ACK, idx, 1'b1);
          end else begin
            add_event(KIND_ERROR, idx, 1'b1);
          end
        end
        OP_DESTROY: begin
          if (alive[idx]) begin
            alive[idx]   = 0;
            running[idx] = 0;
            add_event(KIND_ACK, idx, 1'b1);
          end else begin
            add_event(KIND_ERROR, idx, 1'b1);
          end
        end
        OP_TICK: begin
          // Advance every running timer in slot order; elapsed time saturates.
          for (int s = 0; s < TIMERS; s++) begin
            if (alive[s] && running[s]) begin
              sum = {1'b0, elapsed[s]} + {1'b0, amt};
              elapsed[s] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
              if (elapsed[s] >= duration[s]) begin
                add_event(KIND_EXPIRED, s[3:0], 1'b0);
                if (mode[s] == MODE_LOOP) begin
                  elapsed[s] = '0;
                end else begin
                  running[s] = 0;
                  if (mode[s] == MODE_DESTROY) alive[s] = 0;
                end
              end
            end
          end
          add_event(KIND_TICKDONE, 4'd0, 1'b1);
        end
        default: begin
          add_event(KIND_ERROR, idx, 1'b1);
        end
      endcase
    endfunction

    // Compare one accepted result with the oldest event still due.
    function void check_event(logic [1:0] kind, logic [3:0] slot, logic last);
      timer_event_t e;
      if (events_due.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("ERROR: unexpected result kind=%0d slot=%0d last=%0d", kind, slot, last);
      end else begin
        e = events_due.pop_front();
        if (kind !== e.kind || slot !== e.slot || last !== e.last) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("ERROR: result expected kind=%0d slot=%0d last=%0d",
                     e.kind, e.slot, e.last,
                     ", got kind=%0d slot=%0d last=%0d", kind, slot, last);
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;   // timer_index[3:0], amount[35:4], loop_mode[37:36], zero
  logic [2:0]  s_tuser;   // opcode[2:0]
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;   // slot[3:0], zero
  logic [1:0]  m_tuser;   // kind[1:0]
  logic        m_tlast;

  timer_scoreboard sb;
  int              idle_cycles;
  bit              no_idle;

  multi_channel_timer_bank #(
    .NUM_TIMERS(TIMERS),
    .TIME_BITS (32)
  ) uut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Sample both handshakes at the rising edge and track how long nothing has moved.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (s_tvalid && s_tready)
        sb.note_request(s_tuser, s_tdata[3:0], s_tdata[35:4], s_tdata[37:36]);
      if (m_tvalid && m_tready)
        sb.check_event(m_tuser, m_tdata[3:0], m_tlast);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  // Give up if the block stops moving.
  initial begin : watchdog
    idle_cycles = 0;
    wait (idle_cycles >= STALL_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  // Result side: a random stall before each result, except in stretches without idling.
  initial begin : result_sink
    int stall;
    m_tready <= 1'b0;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 18);
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Present one request after a random gap and hold it until it is taken.
  task automatic send_request(logic [2:0] op, logic [3:0] idx, logic [31:0] amt,
                              logic [1:0] lmode);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 18);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, lmode, amt, idx};
    s_tuser  <= op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Mostly a live slot, sometimes any index so that dead slots get addressed too.
  function automatic logic [3:0] pick_slot();
    int live_q[$];
    for (int s = 0; s < TIMERS; s++)
      if (sb.alive[s]) live_q.push_back(s);
    if (live_q.size() > 0 && $urandom_range(0, 7) != 0)
      return 4'(live_q[$urandom_range(0, live_q.size() - 1)]);
    return 4'($urandom_range(0, TIMERS - 1));
  endfunction

  initial begin : stimulus
    int          sent;
    int          r;
    int          free_slots;
    bit          paused;
    logic [31:0] amt;
    logic [1:0]  lmode;
    sb = new();
    no_idle  = 0;
    paused   = 0;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= OP_CREATE;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part: refused creates, field extremes, saturation and each refusal.
    send_request(OP_CREATE, 4'd0, 32'd0, MODE_ONESHOT);
    send_request(OP_CREATE, 4'd0, 32'd7, MODE_BAD);
    send_request(OP_CREATE, 4'd9, 32'hFFFF_FFFF, MODE_LOOP);
    send_request(OP_CREATE, 4'd0, 32'd1, MODE_ONESHOT);
    send_request(OP_CREATE, 4'd0, 32'd5, MODE_DESTROY);
    send_request(OP_START, 4'd15, 32'd0, MODE_ONESHOT);
    send_request(OP_START, 4'd0, 32'd0, MODE_ONESHOT);
    send_request(OP_START, 4'd1, 32'd0, MODE_ONESHOT);
    send_request(OP_START, 4'd2, 32'd0, MODE_ONESHOT);
    send_request(OP_TICK, 4'd0, 32'd0, MODE_ONESHOT);
    send_request(OP_TICK, 4'd0, 32'd3, MODE_ONESHOT);
    // A full-scale step saturates elapsed time; the looping and destroying timers fire.
    send_request(OP_TICK, 4'd15, 32'hFFFF_FFFF, MODE_BAD);
    send_request(OP_SETDUR, 4'd0, 32'd0, MODE_ONESHOT);
    send_request(OP_SETMODE, 4'd0, 32'd0, MODE_BAD);
    send_request(OP_SETMODE, 4'd1, 32'd0, MODE_LOOP);
    send_request(OP_SETDUR, 4'd0, 32'd10, MODE_ONESHOT);
    send_request(OP_TICK, 4'd0, 32'd4, MODE_ONESHOT);
    // Shrink the duration to the elapsed time; a zero step must still fire it.
    send_request(OP_SETDUR, 4'd0, 32'd4, MODE_ONESHOT);
    send_request(OP_TICK, 4'd0, 32'd0, MODE_ONESHOT);
    send_request(OP_STOP, 4'd0, 32'd0, MODE_ONESHOT);
    send_request(OP_STOP, 4'd0, 32'd0, MODE_ONESHOT);
    send_request(OP_START, 4'd1, 32'd0, MODE_ONESHOT);
    send_request(OP_START, 4'd1, 32'd0, MODE_ONESHOT);
    send_request(OP_DESTROY, 4'd1, 32'd0, MODE_ONESHOT);
    send_request(OP_DESTROY, 4'd1, 32'd0, MODE_ONESHOT);
    send_request(OP_UNUSED, 4'd15, 32'hFFFF_FFFF, MODE_BAD);

    // Random part: mostly well-formed timer traffic with small durations and steps.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent % 30 == 0) no_idle = ($urandom_range(0, 3) == 0);
      // Hold off once until the bank has delivered everything.
      if (!paused && sent >= RANDOM_ITEMS / 2) begin
        paused = 1;
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
      end
      amt   = ($urandom_range(0, 15) == 0) ? 32'd0 : $urandom_range(1, 40);
      lmode = ($urandom_range(0, 15) == 0) ? MODE_BAD : 2'($urandom_range(0, 2));
      r = $urandom_range(0, 99);
      if (r < 6) begin
        // Fill the pool and then ask for one more timer.
        free_slots = 0;
        for (int s = 0; s < TIMERS; s++)
          if (!sb.alive[s]) free_slots++;
        repeat (free_slots + 1) begin
          send_request(OP_CREATE, 4'($urandom_range(0, 15)), $urandom_range(1, 60),
                       2'($urandom_range(0, 2)));
          sent++;
        end
      end else begin
        if (r < 20)
          send_request(OP_CREATE, 4'($urandom_range(0, 15)), amt, lmode);
        else if (r < 33)
          send_request(OP_START, pick_slot(), amt, lmode);
        else if (r < 39)
          send_request(OP_STOP, pick_slot(), amt, lmode);
        else if (r < 45)
          send_request(OP_SETDUR, pick_slot(), amt, lmode);
        else if (r < 51)
          send_request(OP_SETMODE, pick_slot(), amt, lmode);
        else if (r < 58)
          send_request(OP_DESTROY, pick_slot(), amt, lmode);
        else if (r < 88)
          send_request(OP_TICK, 4'($urandom_range(0, 15)),
                       ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 25),
                       2'($urandom_range(0, 3)));
        else
          send_request(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)), $urandom(),
                       2'($urandom_range(0, 3)));
        sent++;
      end
    end
    s_tvalid <= 1'b0;
    no_idle = 0;

    // Drain the remaining results, then watch a little longer for strays.
    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
